// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the markup tag strip core
// Command codes, the status bundle, parser mode codes, character codes and
// the escape table used by the controller, the datapath and the matcher.
// ----------------------------------------------------------------------------
package mts_pkg;

	// Commands issued by the controller to the datapath.
	typedef logic [2:0] cmd_op_t;
	localparam cmd_op_t CMD_NONE  = 3'd0;
	localparam cmd_op_t CMD_IN    = 3'd1;
	localparam cmd_op_t CMD_QUEUE = 3'd2;
	localparam cmd_op_t CMD_FLUSH = 3'd3;
	localparam cmd_op_t CMD_FINAL = 3'd4;

	// Status returned by the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic queue_empty;
		logic esc_open;
	} dp_status_t;

	// Parser modes.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_TEXT = 2'd0;
	localparam mode_t MODE_TAG  = 2'd1;
	localparam mode_t MODE_ESC  = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// Results one string byte may produce; further characters are counted only.
	localparam int MAX_RESULTS = 8;

	// Escape table text, first character in the lowest byte.
	function automatic logic [63:0] esc_text(input logic [3:0] idx);
		logic [63:0] t;
		case (idx)
			4'd0:    t = 64'({">", "r", "b", "<"});
			4'd1:    t = 64'({">", CH_TAB, "<"});
			4'd2:    t = 64'({";", "t", "g"});
			4'd3:    t = 64'({";", "t", "l"});
			4'd4:    t = 64'({";", "p", "m", "a"});
			4'd5:    t = 64'({";", "t", "o", "u", "q"});
			4'd6:    t = 64'({";", "t", "o", "u", "q", "d"});
			default: t = '0;
		endcase
		return t;
	endfunction

	// Escape text length; zero marks an unused slot.
	function automatic logic [3:0] esc_len(input logic [3:0] idx);
		logic [3:0] n;
		case (idx)
			4'd0:    n = 4'd4;
			4'd1:    n = 4'd3;
			4'd2:    n = 4'd3;
			4'd3:    n = 4'd3;
			4'd4:    n = 4'd4;
			4'd5:    n = 4'd5;
			4'd6:    n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Character produced by a full escape match.
	function automatic logic [7:0] esc_value(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:    v = CH_LF;
			4'd1:    v = CH_TAB;
			4'd2:    v = CH_GT;
			4'd3:    v = CH_LT;
			4'd4:    v = CH_AMP;
			4'd5:    v = 8'h27;
			4'd6:    v = 8'h22;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/mts_esc_match.sv =====
// ----------------------------------------------------------------------------
// mts_esc_match: escape table comparator
// Compares the held escape bytes against every table entry in parallel and
// reports the first full match in table order and whether any prefix remains.
// ----------------------------------------------------------------------------
module mts_esc_match #(
	parameter int ESCAPE_COUNT  = 7,
	parameter int PENDING_DEPTH = 6
) (
	input  logic [PENDING_DEPTH*8-1:0] held,
	input  logic [3:0]                 count,
	output logic                       full,
	output logic [7:0]                 value,
	output logic                       candidate
);
	import mts_pkg::*;

	// Each entry compares its first count characters; the lowest full hit wins.
	always_comb begin
		logic [63:0] txt;
		logic [3:0]  len;
		logic        eq;
		full      = 1'b0;
		value     = 8'h00;
		candidate = 1'b0;
		for (int i = 0; i < ESCAPE_COUNT; i++) begin
			txt = esc_text(4'(i));
			len = esc_len(4'(i));
			eq  = 1'b1;
			for (int j = 0; j < PENDING_DEPTH; j++) begin
				if ((4'(j) < count) && (held[j*8 +: 8] != txt[j*8 +: 8])) begin
					eq = 1'b0;
				end
			end
			if ((len != 4'd0) && (count <= len) && eq) begin
				if (count == len) begin
					if (!full) begin
						full  = 1'b1;
						value = esc_value(4'(i));
					end
				end else begin
					candidate = 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath: parser state, escape hold buffer and output stage
// Executes one controller command per cycle: a new byte, a replayed byte,
// an end-of-string escape flush or the closing beat of a string.
// ----------------------------------------------------------------------------
module mts_datapath #(
	parameter int ESCAPE_COUNT  = 7,
	parameter int PENDING_DEPTH = 6,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mts_pkg::cmd_op_t                      cmd,
	input  logic [7:0]                            in_byte,
	output mts_pkg::dp_status_t                   status,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((LENGTH_BITS + 16) / 8) * 8-1:0] m_axis_tdata,
	output logic                                  m_axis_tlast
);
	import mts_pkg::*;

	localparam int IW      = $clog2(PENDING_DEPTH);
	localparam int CW      = $clog2(PENDING_DEPTH + 1);
	localparam int TDATA_W = ((LENGTH_BITS + 16) / 8) * 8;

	// Control state.
	mode_t                  mode_q, mode_d;
	logic [1:0]             tpos_q, tpos_d;
	logic                   bm_q, bm_d;
	logic [IW-1:0]          pc_q, pc_d;
	logic [CW-1:0]          qn_q, qn_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [3:0]             en_q, en_d;
	logic                   hold_v_q, hold_v_d;
	logic                   ov_q;

	// Payload state.
	logic [7:0]             held_q [PENDING_DEPTH];
	logic [7:0]             held_d [PENDING_DEPTH];
	logic [7:0]             hold_b_q;
	logic [7:0]             o_byte_q;
	logic                   o_vbit_q;
	logic                   o_last_q;
	logic [LENGTH_BITS-1:0] o_len_q;

	logic                   from_q;
	logic [7:0]             cur;
	logic [CW-1:0]          qn_after;
	logic [PENDING_DEPTH*8-1:0] match_bytes;
	logic [3:0]             esc_c;
	logic                   esc_full;
	logic [7:0]             esc_val;
	logic                   esc_cand;
	logic                   esc_miss;
	logic                   emit_do;
	logic [7:0]             emit_ch;
	logic [CW-1:0]          shift_amt;
	logic                   wr_en;
	logic [3:0]             en_base;
	logic                   store;
	logic                   push_hold;
	logic                   out_free;

	// Byte under work: the new beat or the head of the replay queue.
	assign from_q   = (cmd == CMD_QUEUE);
	assign cur      = from_q ? held_q[pc_q] : in_byte;
	assign qn_after = qn_q - CW'(from_q);

	// Held escape bytes with the current byte placed after them.
	always_comb begin
		for (int j = 0; j < PENDING_DEPTH; j++) begin
			match_bytes[j*8 +: 8] = (IW'(j) == pc_q) ? cur : held_q[j];
		end
	end
	assign esc_c = 4'(pc_q) + 4'd1;

	mts_esc_match #(
		.ESCAPE_COUNT (ESCAPE_COUNT),
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_match (
		.held     (match_bytes),
		.count    (esc_c),
		.full     (esc_full),
		.value    (esc_val),
		.candidate(esc_cand)
	);

	assign esc_miss = !esc_full && (!esc_cand || (esc_c >= 4'(PENDING_DEPTH)));

	// Parser next state per command.
	always_comb begin
		mode_d    = mode_q;
		tpos_d    = tpos_q;
		bm_d      = bm_q;
		pc_d      = pc_q;
		qn_d      = qn_q;
		emit_do   = 1'b0;
		emit_ch   = 8'h00;
		shift_amt = '0;
		wr_en     = 1'b0;
		case (cmd)
			CMD_IN, CMD_QUEUE: begin
				case (mode_q)
					MODE_TAG: begin
						if (tpos_q == 2'd0) begin
							bm_d = (cur == CH_B);
						end else if (tpos_q == 2'd1) begin
							bm_d = bm_q && (cur == CH_R);
						end else if (tpos_q == 2'd2) begin
							if (bm_q && ((cur == CH_SPACE) || (cur == CH_SLASH) ||
								(cur == CH_GT))) begin
								emit_do = 1'b1;
								emit_ch = CH_LF;
							end
							bm_d = 1'b0;
						end
						if (tpos_q != 2'd3) begin
							tpos_d = tpos_q + 2'd1;
						end
						if (cur == CH_GT) begin
							mode_d = MODE_TEXT;
						end
						if (from_q) begin
							shift_amt = CW'(1);
							qn_d      = qn_after;
						end
					end
					MODE_ESC: begin
						qn_d = qn_after;
						if (esc_full) begin
							emit_do   = 1'b1;
							emit_ch   = esc_val;
							mode_d    = MODE_TEXT;
							pc_d      = '0;
							shift_amt = CW'(pc_q) + CW'(1);
						end else if (esc_miss) begin
							// Give up the escape and replay the held bytes as text.
							emit_do = 1'b1;
							emit_ch = CH_AMP;
							mode_d  = MODE_TEXT;
							pc_d    = '0;
							qn_d    = CW'(pc_q) + CW'(1) + qn_after;
							wr_en   = 1'b1;
						end else begin
							pc_d  = pc_q + IW'(1);
							wr_en = 1'b1;
						end
					end
					default: begin
						if (cur == CH_LT) begin
							mode_d = MODE_TAG;
							tpos_d = 2'd0;
							bm_d   = 1'b0;
						end else if (cur == CH_AMP) begin
							mode_d = MODE_ESC;
							pc_d   = '0;
						end else begin
							emit_do = 1'b1;
							emit_ch = cur;
						end
						if (from_q) begin
							shift_amt = CW'(1);
							qn_d      = qn_after;
						end
					end
				endcase
			end
			CMD_FLUSH: begin
				emit_do = 1'b1;
				emit_ch = CH_AMP;
				mode_d  = MODE_TEXT;
				qn_d    = CW'(pc_q);
				pc_d    = '0;
			end
			CMD_FINAL: begin
				mode_d = MODE_TEXT;
				tpos_d = 2'd0;
				bm_d   = 1'b0;
				pc_d   = '0;
				qn_d   = '0;
			end
			default: begin
			end
		endcase
	end

	// Hold buffer: drop consumed bytes from the front, append the escape byte.
	always_comb begin
		int k;
		for (int j = 0; j < PENDING_DEPTH; j++) begin
			k = j + int'(shift_amt);
			held_d[j] = (k < PENDING_DEPTH) ? held_q[IW'(k)] : held_q[j];
		end
		if (wr_en) begin
			held_d[pc_q] = cur;
		end
	end

	// Result bookkeeping: one character waits in the hold slot so that the
	// closing beat of a string can carry the last flag.
	assign out_free  = !ov_q || m_axis_tready;
	assign en_base   = (cmd == CMD_IN) ? 4'd0 : en_q;
	assign store     = emit_do && (en_base < 4'(MAX_RESULTS));
	assign push_hold = hold_v_q && ((cmd == CMD_IN) || store);

	always_comb begin
		en_d     = en_base + 4'(store);
		hold_v_d = hold_v_q;
		len_d    = len_q;
		if (store) begin
			hold_v_d = 1'b1;
		end else if ((cmd == CMD_IN) || (cmd == CMD_FINAL)) begin
			hold_v_d = 1'b0;
		end
		if (emit_do && (len_q != '1)) begin
			len_d = len_q + LENGTH_BITS'(1);
		end
		if (cmd == CMD_FINAL) begin
			len_d = '0;
			en_d  = 4'd0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_TEXT;
			tpos_q   <= 2'd0;
			bm_q     <= 1'b0;
			pc_q     <= '0;
			qn_q     <= '0;
			len_q    <= '0;
			en_q     <= 4'd0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			tpos_q   <= tpos_d;
			bm_q     <= bm_d;
			pc_q     <= pc_d;
			qn_q     <= qn_d;
			len_q    <= len_d;
			en_q     <= en_d;
			hold_v_q <= hold_v_d;
			if (push_hold || (cmd == CMD_FINAL)) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		held_q <= held_d;
		if (store) begin
			hold_b_q <= emit_ch;
		end
		if (cmd == CMD_FINAL) begin
			o_byte_q <= hold_v_q ? hold_b_q : 8'h00;
			o_vbit_q <= hold_v_q;
			o_last_q <= 1'b1;
			o_len_q  <= len_q;
		end else if (push_hold) begin
			o_byte_q <= hold_b_q;
			o_vbit_q <= 1'b1;
			o_last_q <= 1'b0;
			o_len_q  <= '0;
		end
	end

	assign status.out_free    = out_free;
	assign status.queue_empty = (qn_q == '0);
	assign status.esc_open    = (mode_q == MODE_ESC);

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = TDATA_W'({o_len_q, o_vbit_q, o_byte_q});
	assign m_axis_tlast  = o_last_q;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl: command sequencer of the markup tag strip core
// Takes input beats, schedules replay of abandoned escapes and closes each
// string with a flush of open escapes and a final beat.
// ----------------------------------------------------------------------------
module mts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic                s_axis_tlast,
	input  mts_pkg::dp_status_t status,
	output mts_pkg::cmd_op_t    cmd
);
	import mts_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_d;

	// Replay has priority over new beats; every command needs a free output stage.
	always_comb begin
		state_d       = state_q;
		cmd           = CMD_NONE;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!status.queue_empty) begin
					if (status.out_free) begin
						cmd = CMD_QUEUE;
					end
				end else begin
					s_axis_tready = status.out_free;
					if (s_axis_tvalid && status.out_free) begin
						cmd = CMD_IN;
						if (s_axis_tlast) begin
							state_d = ST_DRAIN;
						end
					end
				end
			end
			ST_DRAIN: begin
				if (status.out_free) begin
					if (!status.queue_empty) begin
						cmd = CMD_QUEUE;
					end else if (status.esc_open) begin
						cmd = CMD_FLUSH;
					end else begin
						cmd     = CMD_FINAL;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/markup_tag_strip_unescape_core.sv =====
// ----------------------------------------------------------------------------
// markup_tag_strip_unescape_core: markup tag stripper and escape decoder
// Turns a markup byte stream into plain text, one input byte per beat.
// ----------------------------------------------------------------------------
// A plain byte or a tag byte passes the parser once. After '&' the bytes
// are held in a PENDING_DEPTH deep buffer and matched against the escape
// table; when they cannot form an escape, '&' goes out and the held bytes
// are replayed through the parser one by one. The last byte of a string is
// followed by a closing beat; an escape still open at that point is first
// given up, and its held bytes are replayed. The output register holds a
// single entry, the parser takes one command per cycle, and any stall on
// the output side holds the parser. The closing beat carries tlast and the
// saturating output length; a string that produces no text still gets one
// closing beat with the valid bit low.
// ----------------------------------------------------------------------------
module markup_tag_strip_unescape_core #(
	parameter int ESCAPE_COUNT  = 7,
	parameter int PENDING_DEPTH = 6,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [7:0]                              s_axis_tdata,  // in_byte
	input  logic                                    s_axis_tlast,  // in_last
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// out_byte [7:0], out_valid [8], total_length [LENGTH_BITS+8:9], zero pad
	output logic [((LENGTH_BITS + 16) / 8) * 8-1:0] m_axis_tdata,
	output logic                                    m_axis_tlast   // out_last
);
	import mts_pkg::*;

	cmd_op_t    cmd;
	dp_status_t status;

	// Sequencer.
	mts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tlast (s_axis_tlast),
		.status       (status),
		.cmd          (cmd)
	);

	// Parser, hold buffer and output stage.
	mts_datapath #(
		.ESCAPE_COUNT (ESCAPE_COUNT),
		.PENDING_DEPTH(PENDING_DEPTH),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_byte      (s_axis_tdata),
		.status       (status),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// New beats are taken only when no replay is pending.
	a_ready_queue: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> status.queue_empty)
		else $error("input ready while replay bytes are pending");

	// No command is issued unless the output stage can take a beat.
	a_cmd_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd != CMD_NONE) |-> status.out_free)
		else $error("command issued while output stage is blocked");

	// Closing a string always presents a last beat next cycle.
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FINAL) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("closing beat missing after final command");
`endif

endmodule
